>>> design/unipolar_stepper_phase_sequencer_core_assert.svh
// Assertion helpers for the stepper phase sequencer.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef UNIPOLAR_STEPPER_PHASE_SEQUENCER_CORE_ASSERT_SVH
`define UNIPOLAR_STEPPER_PHASE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication
`define USPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");

// Next-cycle implication
`define USPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

>>> design/usps_pkg.sv
`timescale 1ns / 1ps
package usps_pkg;

    typedef logic [1:0] t_dir;

    // Direction codes
    localparam t_dir DIR_NONE = 2'd0;
    localparam t_dir DIR_FWD  = 2'd1;
    localparam t_dir DIR_REV  = 2'd2;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HALF_STEP = 2'd0;
    localparam t_cfg_idx CFG_BACKLASH  = 2'd1;
    localparam t_cfg_idx CFG_SQUARE    = 2'd2;
    localparam t_cfg_idx CFG_COILS_EN  = 2'd3;

    localparam int CFG_DATA_BITS = 15;
    localparam int FIELD_POS_BITS = 32;

    // Coil patterns, bit0 = IN1 .. bit3 = IN4
    function automatic logic [3:0] coil_pattern(input logic half, input logic [2:0] phase);
        logic [3:0] pat;
        if (half) begin
            case (phase)
                3'd0:    pat = 4'h1;
                3'd1:    pat = 4'h3;
                3'd2:    pat = 4'h2;
                3'd3:    pat = 4'h6;
                3'd4:    pat = 4'h4;
                3'd5:    pat = 4'hC;
                3'd6:    pat = 4'h8;
                default: pat = 4'h9;
            endcase
        end else begin
            case (phase[1:0])
                2'd0:    pat = 4'h3;
                2'd1:    pat = 4'h6;
                2'd2:    pat = 4'hC;
                default: pat = 4'h9;
            endcase
        end
        return pat;
    endfunction

endpackage

>>> design/unipolar_stepper_phase_sequencer_core.sv
`timescale 1ns / 1ps
// Unipolar stepper phase sequencer with backlash takeup.
// Input channel (i_valid / o_stall): one request per timer tick, carrying the
// tracking rate, the sync flag and an optional new target position.
// Output channel (o_valid / i_stall): one result per request with the coil
// drive bits, motor position, moving direction and backlash flag.
// Configuration: i_cfg_we writes register i_cfg_idx (0 half-step mode,
// 1 backlash amount, 2 square wave, 3 coils enabled) in the same cycle.
// The result of a request is in the output register the cycle after it is
// accepted. Throughput is one request per cycle while no result is stalled;
// the step logic (two signed compares, a position step and a target update)
// sits between the state registers and the result register.
// While the receiver stalls a held result, o_stall is raised and the result
// holds; as soon as the result is taken, a new request is accepted in that
// same cycle. Reset clears all position and backlash state, sets square wave
// mode and leaves the output register empty.
module unipolar_stepper_phase_sequencer_core
    import usps_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int BACKLASH_BITS = 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // request
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [1:0]         i_track_rate,
    input  logic                      i_sync_enable,
    input  logic                      i_load_target,
    input  logic signed [31:0]        i_target_value,
    // result
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [3:0]                o_coils,
    output logic signed [31:0]        o_motor_position,
    output logic [1:0]                o_moving_direction,
    output logic                      o_in_backlash
);

    // configuration registers
    logic                      r_half;
    logic [CFG_DATA_BITS-1:0]  r_amount;
    logic                      r_square;
    logic                      r_coils_en;

    // stepping state
    logic [POSITION_BITS-1:0]  r_target, n_target;
    logic [POSITION_BITS-1:0]  r_cur, n_cur;
    logic [BACKLASH_BITS-1:0]  r_cnt, n_cnt;
    logic                      r_bl, n_bl;
    t_dir                      r_dir, n_dir;
    logic [2:0]                r_phase, n_phase;
    logic                      r_toggle, n_toggle;

    // result register
    logic                      r_out_valid;
    logic [3:0]                r_coils;
    logic [31:0]               r_pos_out;
    t_dir                      r_dir_out;
    logic                      r_bl_out;

    logic                      accept;
    logic                      acts;
    logic                      change;
    logic [POSITION_BITS-1:0]  rate_ext;
    logic [POSITION_BITS-1:0]  tgt_loaded;
    logic [POSITION_BITS-1:0]  tgt_tracked;
    logic [POSITION_BITS+31:0] load_wide;
    logic [POSITION_BITS+31:0] pos_out_wide;
    logic [BACKLASH_BITS+CFG_DATA_BITS-1:0] amount_wide;
    logic [BACKLASH_BITS-1:0]  amount;
    logic [BACKLASH_BITS:0]    cnt_inc;
    logic [2:0]                phase_base;
    logic [2:0]                phase_inc;
    logic [2:0]                phase_dec;
    logic                      go_rev;
    logic                      go_fwd;

    // handshake: a held, stalled result blocks the input
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // operand shaping
    assign load_wide   = {{POSITION_BITS{i_target_value[31]}}, i_target_value};
    assign tgt_loaded  = i_load_target ? load_wide[POSITION_BITS-1:0] : r_target;
    assign rate_ext    = {{(POSITION_BITS-2){i_track_rate[1]}}, i_track_rate};
    assign tgt_tracked = (i_sync_enable && !r_bl) ? tgt_loaded + rate_ext : tgt_loaded;
    assign amount_wide = {{BACKLASH_BITS{1'b0}}, r_amount};
    assign amount      = amount_wide[BACKLASH_BITS-1:0];
    assign cnt_inc     = {1'b0, r_cnt} + 1'b1;

    // phase walk; full-step mode keeps the low two bits
    assign phase_base = r_half ? r_phase : {1'b0, r_phase[1:0]};
    assign phase_inc  = r_half ? phase_base + 3'd1 : {1'b0, phase_base[1:0] + 2'd1};
    assign phase_dec  = r_half ? phase_base - 3'd1 : {1'b0, phase_base[1:0] - 2'd1};

    assign acts   = !r_square || r_toggle;
    assign go_rev = ($signed(r_cur) > $signed(tgt_tracked)) || (r_bl && r_dir == DIR_REV);
    assign go_fwd = ($signed(r_cur) < $signed(tgt_tracked)) || (r_bl && r_dir == DIR_FWD);

    // one tick of the sequencer
    always_comb begin
        n_target = tgt_loaded;
        n_cur    = r_cur;
        n_cnt    = r_cnt;
        n_bl     = r_bl;
        n_dir    = r_dir;
        n_phase  = r_phase;
        n_toggle = !r_toggle;
        change   = 1'b0;
        if (acts) begin
            n_target = tgt_tracked;
            n_phase  = phase_base;
            if (go_rev) begin
                if (r_dir != DIR_REV) begin
                    // direction change: record only, undo tracking
                    n_target = tgt_loaded;
                    n_dir    = DIR_REV;
                    change   = 1'b1;
                end else begin
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - 1'b1;
                        n_bl  = (r_cnt != BACKLASH_BITS'(1));
                    end else begin
                        n_cur = r_cur - 1'b1;
                        n_bl  = 1'b0;
                    end
                    n_phase = phase_dec;
                end
            end else if (go_fwd) begin
                if (r_dir != DIR_FWD) begin
                    n_target = tgt_loaded;
                    n_dir    = DIR_FWD;
                    change   = 1'b1;
                end else begin
                    if (r_cnt < amount) begin
                        n_cnt = cnt_inc[BACKLASH_BITS-1:0];
                        n_bl  = (cnt_inc < {1'b0, amount});
                    end else begin
                        n_cur = r_cur + 1'b1;
                        n_bl  = 1'b0;
                    end
                    n_phase = phase_inc;
                end
            end else if (!r_bl) begin
                n_dir = DIR_NONE;
            end
            n_toggle = (r_square && !change) ? !r_toggle : r_toggle;
        end
    end

    assign pos_out_wide = {32'b0, n_cur};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half     <= 1'b0;
            r_amount   <= '0;
            r_square   <= 1'b1;
            r_coils_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HALF_STEP: r_half     <= i_cfg_data[0];
                CFG_BACKLASH:  r_amount   <= i_cfg_data;
                CFG_SQUARE:    r_square   <= i_cfg_data[0];
                CFG_COILS_EN:  r_coils_en <= i_cfg_data[0];
                default:       r_half     <= r_half;
            endcase
        end
    end

    // stepping state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_cur    <= '0;
            r_cnt    <= '0;
            r_bl     <= 1'b0;
            r_dir    <= DIR_NONE;
            r_phase  <= 3'd0;
            r_toggle <= 1'b0;
        end else if (accept) begin
            r_target <= n_target;
            r_cur    <= n_cur;
            r_cnt    <= n_cnt;
            r_bl     <= n_bl;
            r_dir    <= n_dir;
            r_phase  <= n_phase;
            r_toggle <= n_toggle;
        end else if (i_cfg_we && i_cfg_idx == CFG_COILS_EN && r_coils_en && !i_cfg_data[0]) begin
            // powering the driver down restarts the square-wave cadence, unless a request is accepted at the same edge
            r_toggle <= 1'b0;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coils   <= r_coils_en ? coil_pattern(r_half, n_phase) : 4'h0;
            r_pos_out <= pos_out_wide[31:0];
            r_dir_out <= n_dir;
            r_bl_out  <= n_bl;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_coils            = r_coils;
    assign o_motor_position   = r_pos_out;
    assign o_moving_direction = r_dir_out;
    assign o_in_backlash      = r_bl_out;

`include "unipolar_stepper_phase_sequencer_core_assert.svh"

    // backlash takeup always runs in a known direction
    `USPS_ASSERT_IMP(a_bl_has_dir, r_bl, r_dir == DIR_FWD || r_dir == DIR_REV)
    // an accepted request always yields a result next cycle
    `USPS_ASSERT_NXT(a_accept_yields, accept, r_out_valid)
    // input is held off while a result is stuck
    `USPS_ASSERT_IMP(a_stall_path, r_out_valid && i_stall, !accept)
    // a forward takeup step never carries the backlash counter past the configured amount
    `USPS_ASSERT_IMP(a_cnt_fwd, accept && go_fwd && r_dir == DIR_FWD && r_cnt < amount,
                     n_cnt <= amount)

endmodule

>>> tb/sv/unipolar_stepper_phase_sequencer_core_test.sv
`timescale 1ns / 1ps
module unipolar_stepper_phase_sequencer_core_test;
    import usps_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 12;
    localparam int PHASE_TICKS  = 140;

    // coil patterns, entry n at bits [4n+3:4n]
    localparam logic [15:0] FULL_PAT = 16'h9C63;
    localparam logic [31:0] HALF_PAT = 32'h98C46231;

    typedef struct packed {
        logic [3:0]  coils;
        logic [31:0] pos;
        t_dir        dir;
        logic        bl;
    } t_drive;

    typedef struct packed {
        logic                     is_cfg;
        t_cfg_idx                 idx;
        logic [CFG_DATA_BITS-1:0] data;
        logic [1:0]               rate;
        logic                     sync;
        logic                     load;
        logic [31:0]              value;
        logic                     typed;
        t_drive                   want;
    } t_plan_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [1:0]               i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [1:0]        i_track_rate = '0;
    logic                     i_sync_enable = 1'b0;
    logic                     i_load_target = 1'b0;
    logic signed [31:0]       i_target_value = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [3:0]               o_coils;
    logic signed [31:0]       o_motor_position;
    logic [1:0]               o_moving_direction;
    logic                     o_in_backlash;

    // motor model state and register copies
    logic signed [31:0]       m_target;
    logic signed [31:0]       m_pos;
    logic [14:0]              m_blcount;
    logic [14:0]              m_blamount;
    logic                     m_blactive;
    t_dir                     m_dir;
    logic [2:0]               m_phase;
    logic                     m_toggle;
    logic                     m_half;
    logic                     m_square;
    logic                     m_coils_en;

    t_drive                   expected_drive[$];
    int unsigned              taken_ticks = 0;
    int unsigned              n_bad = 0;
    int unsigned              cycles = 0;
    logic                     gaps_on = 1'b1;
    logic                     row_typed = 1'b0;
    t_drive                   row_want = '0;

    unipolar_stepper_phase_sequencer_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_track_rate       (i_track_rate),
        .i_sync_enable      (i_sync_enable),
        .i_load_target      (i_load_target),
        .i_target_value     (i_target_value),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_coils            (o_coils),
        .o_motor_position   (o_motor_position),
        .o_moving_direction (o_moving_direction),
        .o_in_backlash      (o_in_backlash)
    );

    always #2 i_clk = ~i_clk;

    // one timer tick through the motor model
    task automatic tick_motor(input logic [1:0] rate, input logic sync, input logic load,
                              input logic [31:0] value, output t_drive res);
        logic signed [31:0] saved;
        logic               turned;
        turned = 1'b0;
        if (load) m_target = value;
        if (!m_square || m_toggle) begin
            saved = m_target;
            if (sync && !m_blactive) m_target = m_target + {{30{rate[1]}}, rate};
            if (!m_half) m_phase[2] = 1'b0;
            if (m_pos > m_target || (m_blactive && m_dir == DIR_REV)) begin
                if (m_dir != DIR_REV) begin
                    // turn tick: record direction only, undo tracking
                    m_target = saved;
                    m_dir = DIR_REV;
                    turned = 1'b1;
                end else begin
                    if (m_blcount != 0) begin
                        m_blcount = m_blcount - 1'b1;
                        m_blactive = (m_blcount != 0);
                    end else begin
                        m_pos = m_pos - 1;
                        m_blactive = 1'b0;
                    end
                    if (m_phase == 3'd0) m_phase = m_half ? 3'd7 : 3'd3;
                    else m_phase = m_phase - 1'b1;
                end
            end else if (m_pos < m_target || (m_blactive && m_dir == DIR_FWD)) begin
                if (m_dir != DIR_FWD) begin
                    m_target = saved;
                    m_dir = DIR_FWD;
                    turned = 1'b1;
                end else begin
                    if (m_blcount < m_blamount) begin
                        m_blcount = m_blcount + 1'b1;
                        m_blactive = (m_blcount < m_blamount);
                    end else begin
                        m_pos = m_pos + 1;
                        m_blactive = 1'b0;
                    end
                    if (m_half) m_phase = m_phase + 1'b1;
                    else m_phase = {1'b0, m_phase[1:0] + 2'd1};
                end
            end else if (!m_blactive) begin
                m_dir = DIR_NONE;
            end
            if (m_square && !turned) m_toggle = ~m_toggle;
        end else begin
            m_toggle = ~m_toggle;
        end
        if (!m_coils_en) res.coils = 4'h0;
        else if (m_half) res.coils = HALF_PAT[{m_phase, 2'b00} +: 4];
        else res.coils = FULL_PAT[{m_phase[1:0], 2'b00} +: 4];
        res.pos = m_pos;
        res.dir = m_dir;
        res.bl  = m_blactive;
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin : watch
        t_drive want;
        t_drive predicted;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HALF_STEP: m_half = i_cfg_data[0];
                    CFG_BACKLASH:  m_blamount = i_cfg_data[14:0];
                    CFG_SQUARE:    m_square = i_cfg_data[0];
                    CFG_COILS_EN: begin
                        // switching the driver off restarts the square wave
                        if (m_coils_en && !i_cfg_data[0]) m_toggle = 1'b0;
                        m_coils_en = i_cfg_data[0];
                    end
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                if (expected_drive.size() == 0) begin
                    $error("result with no request outstanding");
                    n_bad++;
                end else begin
                    want = expected_drive.pop_front();
                    if (o_coils !== want.coils) begin
                        $error("coils: expected %h, got %h", want.coils, o_coils);
                        n_bad++;
                    end
                    if (o_motor_position !== want.pos) begin
                        $error("motor_position: expected %0d, got %0d",
                               $signed(want.pos), o_motor_position);
                        n_bad++;
                    end
                    if (o_moving_direction !== want.dir) begin
                        $error("moving_direction: expected %0d, got %0d",
                               want.dir, o_moving_direction);
                        n_bad++;
                    end
                    if (o_in_backlash !== want.bl) begin
                        $error("in_backlash: expected %b, got %b", want.bl, o_in_backlash);
                        n_bad++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                tick_motor(i_track_rate, i_sync_enable, i_load_target, i_target_value,
                           predicted);
                expected_drive.push_back(row_typed ? row_want : predicted);
                taken_ticks++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("[unipolar_stepper_phase_sequencer_core] ERROR");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_stall <= gaps_on && ($urandom_range(99) < 15);
    end

    task automatic send_tick(input logic [1:0] rate, input logic sync, input logic load,
                             input logic [31:0] value, input logic typed, input t_drive want);
        int unsigned goal;
        while (gaps_on && $urandom_range(99) < 15) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_track_rate   = rate;
        i_sync_enable  = sync;
        i_load_target  = load;
        i_target_value = value;
        row_typed      = typed;
        row_want       = want;
        goal           = taken_ticks + 1;
        @(negedge i_clk);
        while (taken_ticks != goal) @(negedge i_clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        i_valid = 1'b0;
        while (expected_drive.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    function automatic t_plan_row tick_row(logic [1:0] rate, logic sync, logic load,
                                           logic [31:0] value);
        t_plan_row r;
        r       = '0;
        r.rate  = rate;
        r.sync  = sync;
        r.load  = load;
        r.value = value;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        t_plan_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_plan_row known(t_plan_row r, logic [3:0] coils, logic [31:0] pos,
                                        t_dir dir, logic bl);
        r.typed      = 1'b1;
        r.want.coils = coils;
        r.want.pos   = pos;
        r.want.dir   = dir;
        r.want.bl    = bl;
        return r;
    endfunction

    initial begin : main
        t_plan_row                plan[$];
        t_plan_row                r;
        logic [CFG_DATA_BITS-1:0] amount;
        logic [1:0]               rate;
        logic                     sync;
        logic                     load;
        logic [31:0]              value;

        // model at reset
        m_target   = '0;
        m_pos      = '0;
        m_blcount  = '0;
        m_blamount = '0;
        m_blactive = 1'b0;
        m_dir      = DIR_NONE;
        m_phase    = '0;
        m_toggle   = 1'b0;
        m_half     = 1'b0;
        m_square   = 1'b1;
        m_coils_en = 1'b0;

        // idle square-wave tick, then a turn tick toward the top of the range
        plan.push_back(known(tick_row(2'b00, 0, 0, 0), 4'h0, 0, DIR_NONE, 0));
        plan.push_back(known(tick_row(2'b00, 0, 1, 32'h7FFF_FFFF), 4'h0, 0, DIR_FWD, 0));
        plan.push_back(cfg_row(CFG_COILS_EN, 1));
        plan.push_back(known(tick_row(2'b00, 0, 0, 0), 4'h6, 1, DIR_FWD, 0));
        plan.push_back(known(tick_row(2'b00, 0, 0, 0), 4'h6, 1, DIR_FWD, 0));
        plan.push_back(cfg_row(CFG_SQUARE, 0));
        // load the minimum and track backward: target wraps
        plan.push_back(tick_row(2'b11, 1, 1, 32'h8000_0000));
        // rate code 10 counts as minus two
        plan.push_back(tick_row(2'b10, 1, 0, 0));
        // reverse turn, then steps down
        plan.push_back(tick_row(2'b00, 0, 1, 0));
        plan.push_back(tick_row(2'b00, 0, 0, 0));
        plan.push_back(cfg_row(CFG_HALF_STEP, 1));
        plan.push_back(tick_row(2'b01, 0, 0, 0));
        plan.push_back(tick_row(2'b00, 0, 0, 0));
        plan.push_back(tick_row(2'b00, 0, 0, 0));
        // largest takeup, tracking held off while it runs
        plan.push_back(cfg_row(CFG_BACKLASH, 15'h7FFF));
        plan.push_back(tick_row(2'b00, 0, 1, 5));
        plan.push_back(tick_row(2'b01, 1, 0, 0));
        plan.push_back(tick_row(2'b01, 1, 0, 0));
        // amount dropped under the count: next forward tick moves at once
        plan.push_back(cfg_row(CFG_BACKLASH, 0));
        plan.push_back(tick_row(2'b00, 0, 0, 0));
        plan.push_back(cfg_row(CFG_BACKLASH, 3));
        plan.push_back(tick_row(2'b00, 0, 1, 32'hFFFF_FFFD));
        plan.push_back(tick_row(2'b01, 1, 0, 0));
        plan.push_back(tick_row(2'b00, 0, 0, 0));
        plan.push_back(tick_row(2'b00, 0, 0, 0));
        plan.push_back(tick_row(2'b11, 1, 0, 0));
        // back to full step with the phase possibly past the short table
        plan.push_back(cfg_row(CFG_HALF_STEP, 0));
        plan.push_back(tick_row(2'b00, 0, 0, 0));
        plan.push_back(cfg_row(CFG_SQUARE, 1));
        plan.push_back(tick_row(2'b00, 0, 1, 32'h7FFF_FFFF));
        plan.push_back(tick_row(2'b01, 1, 0, 0));
        // driver off mid-wave, a non-acting tick, then a load on an acting tick
        plan.push_back(cfg_row(CFG_COILS_EN, 0));
        plan.push_back(tick_row(2'b01, 1, 0, 0));
        plan.push_back(tick_row(2'b00, 0, 1, 32'h0000_0010));
        plan.push_back(tick_row(2'b00, 0, 0, 0));
        plan.push_back(cfg_row(CFG_COILS_EN, 1));

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (plan[n]) begin
            r = plan[n];
            if (r.is_cfg) write_reg(r.idx, r.data);
            else send_tick(r.rate, r.sync, r.load, r.value, r.typed, r.want);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            gaps_on = (ph != 5);
            case (ph)
                0:       amount = '0;
                PHASES - 1: amount = 15'h7FFF;
                default: begin
                    case ($urandom_range(2))
                        0:       amount = 15'($urandom_range(6));
                        1:       amount = 15'($urandom_range(40));
                        default: amount = 15'($urandom_range(32767));
                    endcase
                end
            endcase
            write_reg(CFG_HALF_STEP, 15'($urandom_range(1)));
            write_reg(CFG_BACKLASH, amount);
            write_reg(CFG_SQUARE, 15'($urandom_range(1)));
            write_reg(CFG_COILS_EN, 15'($urandom_range(1)));
            for (int k = 0; k < PHASE_TICKS; k++) begin
                rate = 2'($urandom_range(3));
                sync = ($urandom_range(99) < 60);
                load = ($urandom_range(4) == 0);
                // mostly targets near the motor so it reverses and settles
                if ($urandom_range(3) == 0) value = $urandom;
                else value = m_pos + $urandom_range(40) - 32'd20;
                send_tick(rate, sync, load, value, 1'b0, '0);
                // now and then hold off until everything is back
                if ($urandom_range(99) == 0) begin
                    i_valid = 1'b0;
                    while (expected_drive.size() != 0) @(negedge i_clk);
                end
            end
        end

        i_valid = 1'b0;
        while (expected_drive.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        if (n_bad == 0 && expected_drive.size() == 0) begin
            $display("[unipolar_stepper_phase_sequencer_core] OK");
        end else begin
            $display("[unipolar_stepper_phase_sequencer_core] ERROR");
        end
        $finish;
    end

endmodule
